// File: rtl/mrmf_pkg.sv
// mrmf_pkg: request/result payload types, table entry and command types, MIDI codes.
// Used by every module of the redundant message filter; depends on nothing.
`default_nettype none

package mrmf_pkg;

    localparam int IDX_W = 8;

    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_CC       = 8'hB0;
    localparam logic [7:0] NIB_LO      = 8'h0F;
    localparam logic [7:0] NIB_HI      = 8'hF0;

    localparam logic [1:0] KIND_DECISION = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    localparam logic FUNC_MSG   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic       func;
        logic [3:0] device;
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
    } in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       pass;
        logic       overflow;
        logic [3:0] out_device;
        logic [7:0] out_status;
        logic [7:0] out_data1;
        logic [7:0] out_data2;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [3:0] dev;
        logic [3:0] chan;
        logic [7:0] num;
        logic [7:0] val;
    } entry_t;

    typedef struct packed {
        logic             wr;
        logic             inval;
        logic             clr_all;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } tbl_cmd_t;

    typedef struct packed {
        logic             ack;
        logic             vld;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } tbl_rd_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [7:0]       hit_val;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } match_t;

endpackage

`default_nettype wire

// File: rtl/midi_redundant_message_filter_core.sv
// midi_redundant_message_filter_core: sequencer, request/result registers, note and CC tables.
// Depends on mrmf_pkg, mrmf_table, mrmf_match.
//
//  channel | ports                     | payload
//  --------+---------------------------+------------------
//  request | s_valid s_ready s_data    | mrmf_pkg::in_t
//  result  | m_valid m_ready m_data    | mrmf_pkg::out_t
//
// Note on/off and CC requests scan their table one slot a cycle through the shared
// compare unit. Other messages go straight to the decision.
// Flush: note slots are read in turn, a note off per held note; both tables clear at once.
// Reset clears the valid flops; no clearing pass.
// s_ready is high only while idle; a held result stalls the sequencer at its next result.
`default_nettype none

module midi_redundant_message_filter_core #(
    parameter int NOTE_ENTRIES = 32,
    parameter int CC_ENTRIES   = 32,
    parameter int DEVICE_BITS  = 4
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  mrmf_pkg::in_t   s_data,
    output logic            m_valid,
    input  wire             m_ready,
    output mrmf_pkg::out_t  m_data
);

    localparam logic [3:0] DEV_MASK = 4'((1 << DEVICE_BITS) - 1);
    localparam logic [mrmf_pkg::IDX_W-1:0] NOTE_LAST = mrmf_pkg::IDX_W'(NOTE_ENTRIES - 1);
    localparam logic [mrmf_pkg::IDX_W-1:0] CC_LAST   = mrmf_pkg::IDX_W'(CC_ENTRIES - 1);
    localparam logic [mrmf_pkg::IDX_W-1:0] IDX_ONE   = mrmf_pkg::IDX_W'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_FL_RD  = 3'd5;
    localparam logic [2:0] S_FL_CHK = 3'd6;

    logic [2:0]                 state_reg, state_next;
    mrmf_pkg::in_t              req_reg;
    logic                       sel_cc_reg;
    logic                       flush_reg;
    logic [mrmf_pkg::IDX_W-1:0] scan_idx_reg;
    mrmf_pkg::out_t             res_reg, res_next;
    logic                       m_valid_reg;
    mrmf_pkg::out_t             m_data_reg;

    mrmf_pkg::tbl_cmd_t         note_cmd, cc_cmd;
    mrmf_pkg::tbl_rd_t          note_rd, cc_rd, scan_rd;
    mrmf_pkg::match_t           match;
    logic [NOTE_ENTRIES-1:0]    note_valid;
    logic [CC_ENTRIES-1:0]      cc_valid;
    logic                       note_rd_en, cc_rd_en;

    logic                       accept, put_fire, start;
    logic [3:0]                 dev_key;
    logic [3:0]                 chan;
    logic [7:0]                 st_type, in_type;
    logic                       chan_msg, in_chan_msg, in_note, in_cc;
    logic                       scan_last;
    logic                       notes_above;
    logic                       nz;

    assign accept   = s_valid && s_ready;
    assign put_fire = (state_reg == S_PUT) && (!m_valid_reg || m_ready);
    assign start    = accept;

    assign in_type     = s_data.status & mrmf_pkg::NIB_HI;
    assign in_chan_msg = s_data.status[7] && (in_type != mrmf_pkg::NIB_HI);
    assign in_note     = in_chan_msg &&
                         ((in_type == mrmf_pkg::ST_NOTE_ON) || (in_type == mrmf_pkg::ST_NOTE_OFF));
    assign in_cc       = in_chan_msg && (in_type == mrmf_pkg::ST_CC);

    assign dev_key  = req_reg.device & DEV_MASK;
    assign chan     = 4'(req_reg.status & mrmf_pkg::NIB_LO);
    assign st_type  = req_reg.status & mrmf_pkg::NIB_HI;
    assign chan_msg = req_reg.status[7] && (st_type != mrmf_pkg::NIB_HI);
    assign nz       = (req_reg.data2 != 8'd0);

    assign scan_last   = sel_cc_reg ? (scan_idx_reg == CC_LAST) : (scan_idx_reg == NOTE_LAST);
    assign notes_above = |(note_valid >> ({1'b0, note_rd.idx} + 9'd1));

    assign note_rd_en = ((state_reg == S_SCAN) && !sel_cc_reg) || (state_reg == S_FL_RD);
    assign cc_rd_en   = (state_reg == S_SCAN) && sel_cc_reg;
    assign scan_rd    = sel_cc_reg ? cc_rd : note_rd;

    mrmf_table #(.DEPTH(NOTE_ENTRIES)) u_note_tbl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (note_rd_en),
        .rd_idx    (scan_idx_reg),
        .cmd       (note_cmd),
        .rd        (note_rd),
        .valid_vec (note_valid)
    );

    mrmf_table #(.DEPTH(CC_ENTRIES)) u_cc_tbl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (cc_rd_en),
        .rd_idx    (scan_idx_reg),
        .cmd       (cc_cmd),
        .rd        (cc_rd),
        .valid_vec (cc_valid)
    );

    mrmf_match u_match (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .rd       (scan_rd),
        .key_dev  (dev_key),
        .key_chan (chan),
        .key_num  (req_reg.data1),
        .res      (match)
    );

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        note_cmd   = '0;
        cc_cmd     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.func == mrmf_pkg::FUNC_FLUSH) begin
                        if (note_valid == '0) begin
                            res_next      = '0;
                            res_next.kind = mrmf_pkg::KIND_EMPTY;
                            res_next.last = 1'b1;
                            state_next    = S_PUT;
                        end else begin
                            state_next = S_FL_RD;
                        end
                    end else if (in_note || in_cc) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                res_next.kind       = mrmf_pkg::KIND_DECISION;
                res_next.pass       = 1'b1;
                res_next.overflow   = 1'b0;
                res_next.out_device = dev_key;
                res_next.out_status = req_reg.status;
                res_next.out_data1  = req_reg.data1;
                res_next.out_data2  = req_reg.data2;
                res_next.last       = 1'b1;
                if (chan_msg && (st_type == mrmf_pkg::ST_NOTE_ON)) begin
                    note_cmd.entry = '{dev: dev_key, chan: chan, num: req_reg.data1,
                                       val: {7'd0, nz}};
                    if (match.hit) begin
                        note_cmd.idx = match.hit_idx;
                        if (match.hit_val[0] != nz) begin
                            note_cmd.wr = 1'b1;
                        end else begin
                            res_next.pass = 1'b0;
                        end
                    end else if (match.free) begin
                        note_cmd.idx = match.free_idx;
                        note_cmd.wr  = 1'b1;
                    end else begin
                        res_next.overflow = 1'b1;
                    end
                end else if (chan_msg && (st_type == mrmf_pkg::ST_NOTE_OFF)) begin
                    if (match.hit) begin
                        note_cmd.idx   = match.hit_idx;
                        note_cmd.inval = 1'b1;
                    end else begin
                        res_next.pass = 1'b0;
                    end
                end else if (chan_msg && (st_type == mrmf_pkg::ST_CC)) begin
                    cc_cmd.entry = '{dev: dev_key, chan: chan, num: req_reg.data1,
                                     val: req_reg.data2};
                    if (match.hit) begin
                        cc_cmd.idx = match.hit_idx;
                        if (match.hit_val != req_reg.data2) begin
                            cc_cmd.wr = 1'b1;
                        end else begin
                            res_next.pass = 1'b0;
                        end
                    end else if (match.free) begin
                        cc_cmd.idx = match.free_idx;
                        cc_cmd.wr  = 1'b1;
                    end else begin
                        res_next.overflow = 1'b1;
                    end
                end
                state_next = S_PUT;
            end
            S_PUT: begin
                if (put_fire) begin
                    if (flush_reg && res_reg.last) begin
                        note_cmd.clr_all = 1'b1;
                        cc_cmd.clr_all   = 1'b1;
                        state_next       = S_IDLE;
                    end else if (flush_reg) begin
                        state_next = S_FL_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FL_RD: begin
                state_next = S_FL_CHK;
            end
            S_FL_CHK: begin
                if (note_rd.vld) begin
                    res_next.kind       = mrmf_pkg::KIND_NOTE_OFF;
                    res_next.pass       = 1'b1;
                    res_next.overflow   = 1'b0;
                    res_next.out_device = note_rd.entry.dev;
                    res_next.out_status = mrmf_pkg::ST_NOTE_OFF | {4'd0, note_rd.entry.chan};
                    res_next.out_data1  = note_rd.entry.num;
                    res_next.out_data2  = 8'd0;
                    res_next.last       = !notes_above;
                    state_next          = S_PUT;
                end else begin
                    state_next = S_FL_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            flush_reg   <= 1'b0;
            sel_cc_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (put_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                flush_reg  <= (s_data.func == mrmf_pkg::FUNC_FLUSH);
                sel_cc_reg <= in_cc && (s_data.func == mrmf_pkg::FUNC_MSG);
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            req_reg <= s_data;
        end
        if (accept) begin
            scan_idx_reg <= '0;
        end else if ((state_reg == S_SCAN) && !scan_last) begin
            scan_idx_reg <= scan_idx_reg + IDX_ONE;
        end else if ((state_reg == S_FL_CHK) && !note_rd.vld) begin
            scan_idx_reg <= scan_idx_reg + IDX_ONE;
        end else if (put_fire && flush_reg && !res_reg.last) begin
            scan_idx_reg <= scan_idx_reg + IDX_ONE;
        end
        if (put_fire) begin
            m_data_reg <= res_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (put_fire && flush_reg && res_reg.last) |=> (note_valid == '0) && (cc_valid == '0))
        else $error("tables not cleared after flush");

    a_decision_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.kind == mrmf_pkg::KIND_DECISION)) |-> m_data.last)
        else $error("decision result without last");

    a_noteoff_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.kind == mrmf_pkg::KIND_NOTE_OFF)) |->
        (m_data.pass && !m_data.overflow && (m_data.out_data2 == 8'd0)))
        else $error("malformed generated note off");

    a_idle_between: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

// File: rtl/mrmf_table.sv
// mrmf_table: one key/value table, entry memory with registered read plus valid flops.
// Depends on mrmf_pkg.
`default_nettype none

module mrmf_table #(
    parameter int DEPTH = 32
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           rd_en,
    input  wire  [mrmf_pkg::IDX_W-1:0]    rd_idx,
    input  mrmf_pkg::tbl_cmd_t            cmd,
    output mrmf_pkg::tbl_rd_t             rd,
    output logic [DEPTH-1:0]              valid_vec
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mrmf_pkg::entry_t               mem [DEPTH];
    logic [DEPTH-1:0]               valid_reg;
    logic                           rd_ack_reg;
    logic                           rd_vld_reg;
    logic [mrmf_pkg::IDX_W-1:0]     rd_idx_reg;
    mrmf_pkg::entry_t               rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[cmd.idx[IW-1:0]] <= cmd.entry;
        end
        rd_entry_reg <= mem[rd_idx[IW-1:0]];
        rd_vld_reg   <= valid_reg[rd_idx[IW-1:0]];
        rd_idx_reg   <= rd_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_ack_reg <= 1'b0;
        end else begin
            rd_ack_reg <= rd_en;
            if (cmd.clr_all) begin
                valid_reg <= '0;
            end else if (cmd.wr) begin
                valid_reg[cmd.idx[IW-1:0]] <= 1'b1;
            end else if (cmd.inval) begin
                valid_reg[cmd.idx[IW-1:0]] <= 1'b0;
            end
        end
    end

    assign rd.ack    = rd_ack_reg;
    assign rd.vld    = rd_vld_reg;
    assign rd.idx    = rd_idx_reg;
    assign rd.entry  = rd_entry_reg;
    assign valid_vec = valid_reg;

endmodule

`default_nettype wire

// File: rtl/mrmf_match.sv
// mrmf_match: shared key compare unit, tracks first matching and first free slot over a scan.
// Depends on mrmf_pkg.
`default_nettype none

module mrmf_match (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  mrmf_pkg::tbl_rd_t   rd,
    input  wire  [3:0]          key_dev,
    input  wire  [3:0]          key_chan,
    input  wire  [7:0]          key_num,
    output mrmf_pkg::match_t    res
);

    logic                       hit_reg;
    logic                       free_reg;
    logic [mrmf_pkg::IDX_W-1:0] hit_idx_reg;
    logic [mrmf_pkg::IDX_W-1:0] free_idx_reg;
    logic [7:0]                 hit_val_reg;
    logic                       key_eq;

    assign key_eq = (rd.entry.dev == key_dev) && (rd.entry.chan == key_chan) &&
                    (rd.entry.num == key_num);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (start) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (rd.ack) begin
            if (rd.vld && key_eq && !hit_reg) begin
                hit_reg <= 1'b1;
            end
            if (!rd.vld && !free_reg) begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.ack && rd.vld && key_eq && !hit_reg) begin
            hit_idx_reg <= rd.idx;
            hit_val_reg <= rd.entry.val;
        end
        if (rd.ack && !rd.vld && !free_reg) begin
            free_idx_reg <= rd.idx;
        end
    end

    assign res.hit      = hit_reg;
    assign res.hit_idx  = hit_idx_reg;
    assign res.hit_val  = hit_val_reg;
    assign res.free     = free_reg;
    assign res.free_idx = free_idx_reg;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: drives note, controller, noise and flush requests into the MIDI redundant message
// filter core and checks every result against a behavioral copy of its two key tables.
// Depends on mrmf_pkg and midi_redundant_message_filter_core.

module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SLOTS         = 32;
    localparam int TBL_NOTE      = 0;
    localparam int TBL_CC        = 1;
    localparam int RANDOM_ITEMS  = 66;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_CYCLES  = 20000;
    localparam int TIMEOUT_NS    = 20_000_000;
    localparam int IN_BITS       = $bits(mrmf_pkg::in_t);

    localparam logic [7:0] ST_POLY_AT  = 8'hA0;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_CHAN_AT  = 8'hD0;
    localparam logic [7:0] ST_PITCH    = 8'hE0;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_RESET    = 8'hFF;
    localparam logic [7:0] ST_DATA_MAX = 8'h7F;

    typedef struct packed {
        logic       valid;
        logic [3:0] dev;
        logic [3:0] chan;
        logic [7:0] num;
        logic [7:0] val;
    } slot_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    mrmf_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    mrmf_pkg::out_t m_data;

    slot_t          held_keys[2*SLOTS];
    mrmf_pkg::out_t outcomes_due[$];
    int             fail_count  = 0;
    bit             steady      = 1'b0;
    bit             ready_phase = 1'b0;
    int             phase_left  = 0;

    midi_redundant_message_filter_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void clear_tables();
        int i;
        for (i = 0; i < 2*SLOTS; i++) held_keys[i] = '0;
    endfunction

    function automatic void queue_outcome(mrmf_pkg::out_t r);
        outcomes_due.insert(outcomes_due.size(), r);
    endfunction

    function automatic int find_key(int t, logic [3:0] dev, logic [3:0] chan, logic [7:0] num);
        int i;
        slot_t s;
        for (i = t*SLOTS; i < (t+1)*SLOTS; i++) begin
            s = held_keys[i];
            if (s.valid && s.dev == dev && s.chan == chan && s.num == num) return i;
        end
        return -1;
    endfunction

    function automatic int free_key(int t);
        int i;
        slot_t s;
        for (i = t*SLOTS; i < (t+1)*SLOTS; i++) begin
            s = held_keys[i];
            if (!s.valid) return i;
        end
        return -1;
    endfunction

    // Updates the key tables for one accepted request and queues the results it causes.
    function automatic void apply_filter(mrmf_pkg::in_t req);
        mrmf_pkg::out_t r;
        slot_t          s;
        int             i, k, held, t;
        logic [3:0]     chan;
        logic [7:0]     stored;
        logic [7:0]     st_type;
        r = '0;
        if (req.func == mrmf_pkg::FUNC_FLUSH) begin
            held = 0;
            for (i = 0; i < SLOTS; i++) begin
                s = held_keys[TBL_NOTE*SLOTS + i];
                if (s.valid) held++;
            end
            if (held == 0) begin
                r.kind = mrmf_pkg::KIND_EMPTY;
                r.last = 1'b1;
                queue_outcome(r);
            end
            k = 0;
            for (i = 0; i < SLOTS; i++) begin
                s = held_keys[TBL_NOTE*SLOTS + i];
                if (s.valid) begin
                    k++;
                    r.kind       = mrmf_pkg::KIND_NOTE_OFF;
                    r.pass       = 1'b1;
                    r.overflow   = 1'b0;
                    r.out_device = s.dev;
                    r.out_status = mrmf_pkg::ST_NOTE_OFF | {4'h0, s.chan};
                    r.out_data1  = s.num;
                    r.out_data2  = 8'h00;
                    r.last       = (k == held);
                    queue_outcome(r);
                end
            end
            clear_tables();
            return;
        end

        chan         = req.status[3:0];
        st_type      = req.status & mrmf_pkg::NIB_HI;
        r.kind       = mrmf_pkg::KIND_DECISION;
        r.pass       = 1'b1;
        r.overflow   = 1'b0;
        r.out_device = req.device;
        r.out_status = req.status;
        r.out_data1  = req.data1;
        r.out_data2  = req.data2;
        r.last       = 1'b1;
        if (req.status >= mrmf_pkg::ST_NOTE_OFF && req.status < mrmf_pkg::NIB_HI) begin
            if (st_type == mrmf_pkg::ST_NOTE_ON || st_type == mrmf_pkg::ST_CC) begin
                t      = (st_type == mrmf_pkg::ST_CC) ? TBL_CC : TBL_NOTE;
                stored = (t == TBL_CC) ? req.data2 : {7'h00, req.data2 != 8'h00};
                i      = find_key(t, req.device, chan, req.data1);
                if (i >= 0) begin
                    s = held_keys[i];
                    if (s.val != stored) begin
                        s.val        = stored;
                        held_keys[i] = s;
                    end else begin
                        r.pass = 1'b0;
                    end
                end else begin
                    i = free_key(t);
                    if (i >= 0) begin
                        s.valid      = 1'b1;
                        s.dev        = req.device;
                        s.chan       = chan;
                        s.num        = req.data1;
                        s.val        = stored;
                        held_keys[i] = s;
                    end else begin
                        r.overflow = 1'b1;
                    end
                end
            end else if (st_type == mrmf_pkg::ST_NOTE_OFF) begin
                i = find_key(TBL_NOTE, req.device, chan, req.data1);
                if (i >= 0) begin
                    s            = held_keys[i];
                    s.valid      = 1'b0;
                    held_keys[i] = s;
                end else begin
                    r.pass = 1'b0;
                end
            end
        end
        queue_outcome(r);
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_outcome(mrmf_pkg::out_t got);
        mrmf_pkg::out_t want;
        if (outcomes_due.size() == 0) begin
            $error("result %h with nothing expected", got);
            fail_count++;
        end else begin
            want = outcomes_due[0];
            outcomes_due.delete(0);
            check_field("kind", 8'(want.kind), 8'(got.kind));
            check_field("pass", 8'(want.pass), 8'(got.pass));
            check_field("overflow", 8'(want.overflow), 8'(got.overflow));
            check_field("out_device", 8'(want.out_device), 8'(got.out_device));
            check_field("out_status", want.out_status, got.out_status);
            check_field("out_data1", want.out_data1, got.out_data1);
            check_field("out_data2", want.out_data2, got.out_data2);
            check_field("last", 8'(want.last), 8'(got.last));
        end
    endtask

    // Result side: check, then pick the ready level for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_outcome(m_data);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                ready_phase = !ready_phase;
                phase_left  = ready_phase ? $urandom_range(1, 12) : idle_span();
            end
            phase_left--;
            m_ready <= ready_phase;
        end
    end

    // Valid stays high between back-to-back requests; it only drops for a gap.
    task automatic send_request(mrmf_pkg::in_t req);
        int gap;
        gap = steady ? 0 : (($urandom_range(0, 1) == 0) ? 0 : idle_span());
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_filter(req);
    endtask

    function automatic mrmf_pkg::in_t channel_msg(logic [3:0] dev, logic [7:0] st,
                                                  logic [7:0] d1, logic [7:0] d2);
        mrmf_pkg::in_t req;
        req.func   = mrmf_pkg::FUNC_MSG;
        req.device = dev;
        req.status = st;
        req.data1  = d1;
        req.data2  = d2;
        return req;
    endfunction

    function automatic mrmf_pkg::in_t flush_req();
        mrmf_pkg::in_t req;
        req      = IN_BITS'($urandom);
        req.func = mrmf_pkg::FUNC_FLUSH;
        return req;
    endfunction

    task automatic test_directed();
        send_request(flush_req());
        send_request(channel_msg(4'h0, mrmf_pkg::ST_NOTE_ON, 8'd60, 8'd100));
        send_request(channel_msg(4'h0, mrmf_pkg::ST_NOTE_ON, 8'd60, 8'd1));
        send_request(channel_msg(4'h0, mrmf_pkg::ST_NOTE_ON, 8'd60, 8'd0));
        send_request(channel_msg(4'h0, mrmf_pkg::ST_NOTE_ON, 8'd60, 8'd0));
        send_request(channel_msg(4'h0, mrmf_pkg::ST_NOTE_ON, 8'd60, 8'd127));
        send_request(channel_msg(4'h0, mrmf_pkg::ST_NOTE_OFF, 8'd60, 8'd64));
        send_request(channel_msg(4'h0, mrmf_pkg::ST_NOTE_OFF, 8'd60, 8'd64));
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_ON | mrmf_pkg::NIB_LO, 8'hFF, 8'hFF));
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_ON | mrmf_pkg::NIB_LO, 8'h00, 8'h00));
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_ON | 8'h0E, 8'hFF, 8'h80));
        send_request(channel_msg(4'h3, mrmf_pkg::ST_CC | 8'h05, 8'd7, 8'h00));
        send_request(channel_msg(4'h3, mrmf_pkg::ST_CC | 8'h05, 8'd7, 8'h00));
        send_request(channel_msg(4'h3, mrmf_pkg::ST_CC | 8'h05, 8'd7, 8'hFF));
        send_request(channel_msg(4'h3, mrmf_pkg::ST_CC | 8'h05, 8'hFF, 8'hFF));
        send_request(channel_msg(4'h5, ST_POLY_AT | 8'h05, 8'hFF, 8'hFF));
        send_request(channel_msg(4'h6, ST_PROGRAM | 8'h03, 8'd10, 8'd0));
        send_request(channel_msg(4'h7, ST_CHAN_AT, 8'd20, 8'd30));
        send_request(channel_msg(4'h8, ST_PITCH | mrmf_pkg::NIB_LO, 8'h00, 8'h40));
        send_request(channel_msg(4'h0, 8'h00, 8'd60, 8'd100));
        send_request(channel_msg(4'h9, ST_DATA_MAX, 8'hAA, 8'h55));
        send_request(channel_msg(4'hA, ST_SYSEX, 8'h7E, 8'h7F));
        send_request(channel_msg(4'hB, ST_RESET, 8'hFF, 8'hFF));
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_OFF | mrmf_pkg::NIB_LO, 8'h00, 8'hFF));
        send_request(flush_req());
        send_request(flush_req());
    endtask

    task automatic test_note_overflow();
        logic [3:0] dev[SLOTS];
        logic [7:0] st[SLOTS];
        logic [7:0] num[SLOTS];
        int         i;
        for (i = 0; i < SLOTS; i++) begin
            dev[i] = 4'($urandom_range(0, 14));
            st[i]  = mrmf_pkg::ST_NOTE_ON | 8'($urandom_range(0, 15));
            num[i] = 8'(($urandom_range(0, 7) << 5) | i);
            send_request(channel_msg(dev[i], st[i], num[i], 8'($urandom_range(1, 255))));
        end
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_ON, 8'h40, 8'h7F));
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_OFF, 8'h40, 8'h00));
        send_request(channel_msg(dev[7], st[7], num[7], 8'h55));
        send_request(channel_msg(dev[7], st[7], num[7], 8'h00));
        send_request(channel_msg(dev[5], (st[5] & mrmf_pkg::NIB_LO) | mrmf_pkg::ST_NOTE_OFF,
                                 num[5], 8'h00));
        // freed slot is reused, so the flush order moves this note
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_ON, 8'h40, 8'h7F));
        send_request(flush_req());
    endtask

    task automatic test_cc_overflow();
        logic [3:0] dev[SLOTS];
        logic [7:0] st[SLOTS];
        logic [7:0] num[SLOTS];
        logic [7:0] val[SLOTS];
        int         i;
        for (i = 0; i < SLOTS; i++) begin
            dev[i] = 4'($urandom_range(0, 14));
            st[i]  = mrmf_pkg::ST_CC | 8'($urandom_range(0, 15));
            num[i] = 8'(($urandom_range(0, 7) << 5) | i);
            val[i] = 8'($urandom);
            send_request(channel_msg(dev[i], st[i], num[i], val[i]));
        end
        send_request(channel_msg(4'hF, mrmf_pkg::ST_CC | mrmf_pkg::NIB_LO, 8'h01, 8'h02));
        send_request(channel_msg(4'hF, mrmf_pkg::ST_CC | mrmf_pkg::NIB_LO, 8'h01, 8'h02));
        send_request(channel_msg(4'hF, mrmf_pkg::ST_NOTE_ON | 8'h02, 8'h30, 8'h40));
        send_request(channel_msg(dev[3], st[3], num[3], val[3]));
        send_request(channel_msg(dev[3], st[3], num[3], val[3] ^ 8'h01));
        send_request(flush_req());
        send_request(channel_msg(dev[0], st[0], num[0], val[0]));
        send_request(flush_req());
    endtask

    task automatic test_random_traffic();
        int            n, r;
        logic [3:0]    dev, chan;
        logic [7:0]    note;
        mrmf_pkg::in_t req;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 30 && n < 55);
            r      = $urandom_range(0, 99);
            dev    = 4'($urandom_range(0, 1));
            chan   = 4'($urandom_range(0, 1));
            note   = 8'(60 + $urandom_range(0, 3));
            if (r < 35) begin
                req = channel_msg(dev, mrmf_pkg::ST_NOTE_ON | {4'h0, chan}, note,
                                  ($urandom_range(0, 2) == 0) ? 8'h00 :
                                  8'($urandom_range(1, 255)));
            end else if (r < 60) begin
                req = channel_msg(dev, mrmf_pkg::ST_NOTE_OFF | {4'h0, chan}, note,
                                  8'($urandom));
            end else if (r < 80) begin
                req = channel_msg(dev, mrmf_pkg::ST_CC | {4'h0, chan},
                                  8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
            end else if (r < 95) begin
                req      = IN_BITS'($urandom);
                req.func = mrmf_pkg::FUNC_MSG;
            end else begin
                req = flush_req();
            end
            send_request(req);
        end
        steady = 1'b0;
    endtask

    initial begin
        int w;
        clear_tables();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_note_overflow();
        test_cc_overflow();
        test_random_traffic();
        s_valid <= 1'b0;
        for (w = 0; w < DRAIN_CYCLES && outcomes_due.size() != 0; w++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (outcomes_due.size() != 0) begin
            $error("%0d expected results never arrived", outcomes_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
